@@ sv/rgab_pkg.sv @@
`default_nettype none

package rgab_pkg;

    localparam int MAX_FRAME_DIM = 8192;
    localparam int COORD_W = $clog2(MAX_FRAME_DIM);
    localparam int CH_W = 8;
    localparam int SQ_W = 2 * COORD_W;
    localparam int NUM_W = SQ_W + CH_W;
    localparam int PROD_W = 2 * CH_W;
    localparam int DIV_STEPS = CH_W;

    localparam logic [CH_W-1:0] FULL = 8'd255;

    localparam int REG_COUNT = 7;
    localparam int ADDR_W = $clog2(4 * REG_COUNT);
    localparam int IDX_W = ADDR_W - 2;

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_GLOW_RADIUS,
        REG_GLOW_RED,
        REG_GLOW_GREEN,
        REG_GLOW_BLUE,
        REG_MAX_ALPHA
    } reg_idx_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] glow_radius;
        logic [CH_W-1:0]    glow_red;
        logic [CH_W-1:0]    glow_green;
        logic [CH_W-1:0]    glow_blue;
        logic [CH_W-1:0]    max_alpha;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic in_circle;
        rgb_t color;
    } pix_t;

    // floor(x / 255) for x below 255*256, reciprocal multiply plus one correction
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W+CH_W-1:0] p;
        logic [CH_W-1:0]        q;
        logic [PROD_W:0]        r;
        p = {x, 8'b0} + {8'b0, x};
        q = p[PROD_W+CH_W-1:PROD_W];
        r = {1'b0, x} - ({1'b0, q, 8'b0} - {9'b0, q});
        if (r >= {9'b0, FULL})
        begin
            q = q + 8'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

@@ sv/rgab_dist.sv @@
`default_nettype none

module rgab_dist
    import rgab_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [COORD_W-1:0] pixel_x,
    input  wire logic [COORD_W-1:0] pixel_y,
    input  wire rgb_t               in_color,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [SQ_W-1:0]         out_n,
    output logic [SQ_W-1:0]         out_r2,
    output pix_t                    out_pix
);

    logic [2:0] v_reg;
    logic [2:0] rdy;

    logic [COORD_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    rgb_t               col1_reg, col2_reg;
    logic [SQ_W-1:0]    dx2_reg, dy2_reg, r2a_reg;
    logic [SQ_W-1:0]    n_reg, r2b_reg, n_next;
    logic [SQ_W:0]      d2_next;
    pix_t               pix3_reg, pix3_next;

    always_comb
    begin
        rdy[2] = !v_reg[2] || out_ready;
        rdy[1] = !v_reg[1] || rdy[2];
        rdy[0] = !v_reg[0] || rdy[1];
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (rdy[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    // absolute offsets from the center
    always_comb
    begin
        dx_next = (pixel_x >= cfg.center_x) ? pixel_x - cfg.center_x : cfg.center_x - pixel_x;
        dy_next = (pixel_y >= cfg.center_y) ? pixel_y - cfg.center_y : cfg.center_y - pixel_y;
    end

    // d2 against r2, n = r2 - d2 only meaningful when inside
    always_comb
    begin
        d2_next = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        n_next = r2a_reg - d2_next[SQ_W-1:0];
        pix3_next.in_circle = (r2a_reg != '0) && (d2_next < {1'b0, r2a_reg});
        pix3_next.color = col2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            col1_reg <= in_color;
        end
        if (rdy[1])
        begin
            dx2_reg <= {{COORD_W{1'b0}}, dx_reg} * {{COORD_W{1'b0}}, dx_reg};
            dy2_reg <= {{COORD_W{1'b0}}, dy_reg} * {{COORD_W{1'b0}}, dy_reg};
            r2a_reg <= {{COORD_W{1'b0}}, cfg.glow_radius}
                     * {{COORD_W{1'b0}}, cfg.glow_radius};
            col2_reg <= col1_reg;
        end
        if (rdy[2])
        begin
            n_reg <= n_next;
            r2b_reg <= r2a_reg;
            pix3_reg <= pix3_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_n = n_reg;
    assign out_r2 = r2b_reg;
    assign out_pix = pix3_reg;

endmodule

`default_nettype wire

@@ sv/rgab_div.sv @@
`default_nettype none

module rgab_div
    import rgab_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [SQ_W-1:0] in_n,
    input  wire logic [SQ_W-1:0] in_r2,
    input  wire pix_t            in_pix,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [CH_W-1:0]      out_f,
    output pix_t                 out_pix
);

    // stage 0 forms n*255, stages 1..8 each retire one quotient bit
    localparam int NST = DIV_STEPS + 1;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;

    logic [SQ_W-1:0] rem_reg [NST];
    logic [SQ_W-1:0] rem_next [NST];
    logic [CH_W-1:0] lo_reg [NST];
    logic [CH_W-1:0] lo_next [NST];
    logic [CH_W-1:0] q_reg [NST];
    logic [CH_W-1:0] q_next [NST];
    logic [SQ_W-1:0] dsr_reg [NST];
    logic [SQ_W-1:0] dsr_next [NST];
    pix_t            pix_reg [NST];
    pix_t            pix_next [NST];

    logic [NUM_W-1:0] num;

    always_comb
    begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        logic [SQ_W:0] trial;
        logic          ge;
        // quotient stays below 256, so the top part is already below the divisor
        num = {in_n, 8'b0} - {8'b0, in_n};
        rem_next[0] = num[NUM_W-1:CH_W];
        lo_next[0] = num[CH_W-1:0];
        q_next[0] = '0;
        dsr_next[0] = in_r2;
        pix_next[0] = in_pix;
        for (int s = 1; s < NST; s++)
        begin
            trial = {rem_reg[s-1], lo_reg[s-1][CH_W-1]};
            ge = trial >= {1'b0, dsr_reg[s-1]};
            if (ge)
            begin
                trial = trial - {1'b0, dsr_reg[s-1]};
            end
            rem_next[s] = trial[SQ_W-1:0];
            lo_next[s] = {lo_reg[s-1][CH_W-2:0], 1'b0};
            q_next[s] = {q_reg[s-1][CH_W-2:0], ge};
            dsr_next[s] = dsr_reg[s-1];
            pix_next[s] = pix_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (rdy[k])
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k] <= lo_next[k];
                q_reg[k] <= q_next[k];
                dsr_reg[k] <= dsr_next[k];
                pix_reg[k] <= pix_next[k];
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_f = q_reg[NST-1];
    assign out_pix = pix_reg[NST-1];

endmodule

`default_nettype wire

@@ sv/rgab_alpha.sv @@
`default_nettype none

module rgab_alpha
    import rgab_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [CH_W-1:0] max_alpha,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [CH_W-1:0] in_f,
    input  wire pix_t            in_pix,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [CH_W-1:0]      out_alpha,
    output rgb_t                 out_color
);

    logic [3:0] v_reg;
    logic [3:0] rdy;

    logic [PROD_W-1:0] x1_reg, x2_reg;
    logic [CH_W-1:0]   f0_reg, f1_reg, q1_reg, a_reg, a_next;
    pix_t              pix0_reg, pix1_reg, pix2_reg;
    rgb_t              col3_reg;

    always_comb
    begin
        rdy[3] = !v_reg[3] || out_ready;
        rdy[2] = !v_reg[2] || rdy[3];
        rdy[1] = !v_reg[1] || rdy[2];
        rdy[0] = !v_reg[0] || rdy[1];
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (rdy[2])
            begin
                v_reg[2] <= v_reg[1];
            end
            if (rdy[3])
            begin
                v_reg[3] <= v_reg[2];
            end
        end
    end

    // zero opacity outside the circle makes the blend a pass-through
    assign a_next = pix2_reg.in_circle ? div255(x2_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x1_reg <= {8'b0, max_alpha} * {8'b0, in_f};
            f0_reg <= in_f;
            pix0_reg <= in_pix;
        end
        if (rdy[1])
        begin
            q1_reg <= div255(x1_reg);
            f1_reg <= f0_reg;
            pix1_reg <= pix0_reg;
        end
        if (rdy[2])
        begin
            x2_reg <= {8'b0, q1_reg} * {8'b0, f1_reg};
            pix2_reg <= pix1_reg;
        end
        if (rdy[3])
        begin
            a_reg <= a_next;
            col3_reg <= pix2_reg.color;
        end
    end

    assign out_valid = v_reg[3];
    assign out_alpha = a_reg;
    assign out_color = col3_reg;

endmodule

`default_nettype wire

@@ sv/rgab_mix.sv @@
`default_nettype none

module rgab_mix
    import rgab_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cfg_t            cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [CH_W-1:0] in_alpha,
    input  wire rgb_t            in_color,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rgb_t                 out_color
);

    logic [1:0] v_reg;
    logic [1:0] rdy;

    logic [CH_W-1:0]   inv_a;
    logic [PROD_W-1:0] sr_reg, sg_reg, sb_reg;
    logic [PROD_W-1:0] sr_next, sg_next, sb_next;
    rgb_t              col_reg, col_next;

    always_comb
    begin
        rdy[1] = !v_reg[1] || out_ready;
        rdy[0] = !v_reg[0] || rdy[1];
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    // weighted sums peak at 255*255, so they fit 16 bits
    always_comb
    begin
        inv_a = FULL - in_alpha;
        sr_next = {8'b0, cfg.glow_red} * {8'b0, in_alpha}
                + {8'b0, in_color.red} * {8'b0, inv_a};
        sg_next = {8'b0, cfg.glow_green} * {8'b0, in_alpha}
                + {8'b0, in_color.green} * {8'b0, inv_a};
        sb_next = {8'b0, cfg.glow_blue} * {8'b0, in_alpha}
                + {8'b0, in_color.blue} * {8'b0, inv_a};
        col_next.red = div255(sr_reg);
        col_next.green = div255(sg_reg);
        col_next.blue = div255(sb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            sr_reg <= sr_next;
            sg_reg <= sg_next;
            sb_reg <= sb_next;
        end
        if (rdy[1])
        begin
            col_reg <= col_next;
        end
    end

    assign out_valid = v_reg[1];
    assign out_color = col_reg;

endmodule

`default_nettype wire

@@ sv/radial_glow_alpha_blend_top.sv @@
// register stages from an accepted input beat to its output beat
//   (distance 3, falloff divider 9, opacity 4, blend 2)
// throughput: one pixel per cycle unless stalled, one falloff quotient bit per stage
// a stalled output fills pipeline bubbles before holding the input side
// reset: asynchronous active-low, clears all valid bits and the glow registers to zero
`default_nettype none

module radial_glow_alpha_blend_top
    import rgab_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // pixel input
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // [12:0] pixel_x, [25:13] pixel_y, [33:26] in_red, [41:34] in_green,
    // [49:42] in_blue, [55:50] zero
    input  wire logic [55:0]       s_axis_tdata,
    // pixel output
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [23:0]            m_axis_tdata
);

    localparam int X_LO = 0;
    localparam int Y_LO = X_LO + COORD_W;
    localparam int R_LO = Y_LO + COORD_W;
    localparam int G_LO = R_LO + CH_W;
    localparam int B_LO = G_LO + CH_W;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    // stage-to-stage links
    logic            d_valid, d_ready;
    logic [SQ_W-1:0] d_n, d_r2;
    pix_t            d_pix;
    logic            q_valid, q_ready;
    logic [CH_W-1:0] q_f;
    pix_t            q_pix;
    logic            a_valid, a_ready;
    logic [CH_W-1:0] a_alpha;
    rgb_t            a_color;
    rgb_t            in_color, out_color;

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    // register decode, unknown indexes drop the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_CENTER_X:    cfg_next.center_x = pwdata[COORD_W-1:0];
                REG_CENTER_Y:    cfg_next.center_y = pwdata[COORD_W-1:0];
                REG_GLOW_RADIUS: cfg_next.glow_radius = pwdata[COORD_W-1:0];
                REG_GLOW_RED:    cfg_next.glow_red = pwdata[CH_W-1:0];
                REG_GLOW_GREEN:  cfg_next.glow_green = pwdata[CH_W-1:0];
                REG_GLOW_BLUE:   cfg_next.glow_blue = pwdata[CH_W-1:0];
                REG_MAX_ALPHA:   cfg_next.max_alpha = pwdata[CH_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // readback
    always_comb
    begin
        unique case (reg_idx)
            REG_CENTER_X:    prdata = {{(32 - COORD_W){1'b0}}, cfg_reg.center_x};
            REG_CENTER_Y:    prdata = {{(32 - COORD_W){1'b0}}, cfg_reg.center_y};
            REG_GLOW_RADIUS: prdata = {{(32 - COORD_W){1'b0}}, cfg_reg.glow_radius};
            REG_GLOW_RED:    prdata = {{(32 - CH_W){1'b0}}, cfg_reg.glow_red};
            REG_GLOW_GREEN:  prdata = {{(32 - CH_W){1'b0}}, cfg_reg.glow_green};
            REG_GLOW_BLUE:   prdata = {{(32 - CH_W){1'b0}}, cfg_reg.glow_blue};
            REG_MAX_ALPHA:   prdata = {{(32 - CH_W){1'b0}}, cfg_reg.max_alpha};
            default:         prdata = '0;
        endcase
    end

    // ---------------- pixel pipeline ----------------
    // the user must change the registers only while no beat is in flight; the block
    // does not enforce this, and each stage reads them directly
    assign in_color.red = s_axis_tdata[R_LO +: CH_W];
    assign in_color.green = s_axis_tdata[G_LO +: CH_W];
    assign in_color.blue = s_axis_tdata[B_LO +: CH_W];

    // squared distance, squared radius, inside test
    rgab_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pixel_x   (s_axis_tdata[X_LO +: COORD_W]),
        .pixel_y   (s_axis_tdata[Y_LO +: COORD_W]),
        .in_color  (in_color),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_n     (d_n),
        .out_r2    (d_r2),
        .out_pix   (d_pix)
    );

    // falloff f = (r2 - d2) * 255 / r2, one quotient bit per stage
    rgab_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_n      (d_n),
        .in_r2     (d_r2),
        .in_pix    (d_pix),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_f     (q_f),
        .out_pix   (q_pix)
    );

    // opacity from falloff and peak alpha
    rgab_alpha u_alpha (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_alpha (cfg_reg.max_alpha),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_f      (q_f),
        .in_pix    (q_pix),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_alpha (a_alpha),
        .out_color (a_color)
    );

    // per-channel blend, last stage is the output register
    rgab_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_alpha  (a_alpha),
        .in_color  (a_color),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_color (out_color)
    );

    assign m_axis_tdata = {out_color.blue, out_color.green, out_color.red};

endmodule

`default_nettype wire
